FILE: rtl/alt_pkg.sv
// ----------------------------------------------------------------------------
// Address lease table package
// Shared types, codes and constants of the lease table and its cells.
// ----------------------------------------------------------------------------
package alt_pkg;

	localparam int DEF_LEASE_SLOTS = 64;
	localparam int DEF_IDX_W       = 6;

	// Offsets below pool_size always fit in seven bits.
	localparam int POOL_OFF_W = 7;
	localparam int POOL_SPAN  = 128;

	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_DISCOVER = 3'd1;
	localparam logic [2:0] MODE_SELECT   = 3'd2;
	localparam logic [2:0] MODE_RENEW    = 3'd3;
	localparam logic [2:0] MODE_RELEASE  = 3'd4;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_OFFER = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_NAK   = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_REFUSED   = 2'd3;

	localparam logic [1:0] CFG_POOL_START     = 2'd0;
	localparam logic [1:0] CFG_POOL_SIZE      = 2'd1;
	localparam logic [1:0] CFG_LEASE_DURATION = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INJECT,
		ST_SCAN,
		ST_EVAL,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [47:0] client_mac;
		logic [31:0] requested_ip;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [31:0] assigned_ip;
		logic [1:0]  status_code;
	} rsp_t;

	// Search key and pool window broadcast to every cell during a scan.
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] req;
		logic [31:0] pool_start;
		logic [6:0]  pool_size;
	} query_t;

	// Scan token that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic                 tv;
		logic                 mac_hit;
		logic [31:0]          mac_addr;
		logic                 addr_hit;
		logic [47:0]          addr_mac;
		logic [31:0]          addr_stamp;
		logic                 free_hit;
		logic [POOL_SPAN-1:0] taken;
	} scan_t;

	// Broadcast write command; only the addressed cell acts on it.
	typedef struct packed {
		logic        en;
		logic        load_lease;
		logic        load_stamp;
		logic        clear;
		logic [47:0] mac;
		logic [31:0] addr;
		logic [31:0] stamp;
	} cell_wr_t;

endpackage

FILE: rtl/alt_cell.sv
// ----------------------------------------------------------------------------
// Lease cell
// Holds one lease slot and updates the scan token passing through it.
// ----------------------------------------------------------------------------
module alt_cell #(
	parameter int IDX_W    = alt_pkg::DEF_IDX_W,
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  alt_pkg::query_t   query,
	input  alt_pkg::cell_wr_t wr,
	input  logic [IDX_W-1:0]  wr_idx,
	input  alt_pkg::scan_t    tok_in,
	input  logic [IDX_W-1:0]  mac_idx_in,
	input  logic [IDX_W-1:0]  addr_idx_in,
	input  logic [IDX_W-1:0]  free_idx_in,
	output alt_pkg::scan_t    tok_out,
	output logic [IDX_W-1:0]  mac_idx_out,
	output logic [IDX_W-1:0]  addr_idx_out,
	output logic [IDX_W-1:0]  free_idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic             valid_q;
	logic [47:0]      mac_q;
	logic [31:0]      addr_q;
	logic [31:0]      stamp_q;
	alt_pkg::scan_t   tok_d;
	alt_pkg::scan_t   tok_q;
	logic [IDX_W-1:0] mi_d, ai_d, fi_d;
	logic [IDX_W-1:0] mi_q, ai_q, fi_q;
	logic [31:0]      own_off;
	logic             sel;

	assign sel     = wr.en && (wr_idx == MY_IDX);
	assign own_off = addr_q - query.pool_start;

	// The first matching cell on the way claims each hit.
	always_comb begin
		tok_d = tok_in;
		mi_d  = mac_idx_in;
		ai_d  = addr_idx_in;
		fi_d  = free_idx_in;
		if (valid_q && mac_q == query.mac && !tok_in.mac_hit) begin
			tok_d.mac_hit  = 1'b1;
			tok_d.mac_addr = addr_q;
			mi_d           = MY_IDX;
		end
		if (valid_q && addr_q == query.req && !tok_in.addr_hit) begin
			tok_d.addr_hit   = 1'b1;
			tok_d.addr_mac   = mac_q;
			tok_d.addr_stamp = stamp_q;
			ai_d             = MY_IDX;
		end
		if (!valid_q && !tok_in.free_hit) begin
			tok_d.free_hit = 1'b1;
			fi_d           = MY_IDX;
		end
		if (valid_q && own_off < 32'(query.pool_size)) begin
			tok_d.taken[own_off[alt_pkg::POOL_OFF_W-1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
			mi_q    <= '0;
			ai_q    <= '0;
			fi_q    <= '0;
		end else begin
			tok_q <= tok_d;
			mi_q  <= mi_d;
			ai_q  <= ai_d;
			fi_q  <= fi_d;
			if (sel && wr.load_lease) begin
				valid_q <= 1'b1;
			end else if (sel && wr.clear) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && wr.load_lease) begin
			mac_q   <= wr.mac;
			addr_q  <= wr.addr;
			stamp_q <= wr.stamp;
		end else if (sel && wr.load_stamp) begin
			stamp_q <= wr.stamp;
		end
	end

	assign tok_out      = tok_q;
	assign mac_idx_out  = mi_q;
	assign addr_idx_out = ai_q;
	assign free_idx_out = fi_q;

endmodule

FILE: rtl/address_lease_table_core.sv
// ----------------------------------------------------------------------------
// Address lease table core
// Lease table of an address-assignment server built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The table holds LEASE_SLOTS leases, one per cell of a chain. Each discover,
// select, renew or release item launches a scan token at the chain's head. The
// token moves one cell per cycle and collects four things: the client's first
// lease, the first lease of the requested address, the first free slot and a
// bitmap of the pool offsets that are already held. A tick or an unknown mode
// passes only through the accepting step and a finishing step. The others
// pass through accept, launch, the scan along the chain, a decision step and
// a finishing step. A discover or renew for a client with no lease, while the
// lease count is below pool_size, also walks the bitmap for the lowest free
// offset between the decision and finishing steps. The finishing step repeats
// for as long as the previous response still waits, stalled, in the output
// register. One item is handled at a time; a finished response sits in that
// output register, so the next command item is taken while the response still
// waits to be read. The configuration registers should be written only while
// no item is in flight; the write port does not check this.
// ----------------------------------------------------------------------------
module address_lease_table_core #(
	parameter int LEASE_SLOTS = alt_pkg::DEF_LEASE_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  alt_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output alt_pkg::rsp_t rsp,
	input  logic          cfg_wen,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
	localparam int CNT_W = $clog2(LEASE_SLOTS + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LEASE_SLOTS);

	alt_pkg::state_t  state_q, state_d;

	// Configuration registers.
	logic [31:0] pool_start_q;
	logic [6:0]  pool_size_q;
	logic [31:0] duration_q;

	logic [31:0]      tick_q;
	logic [CNT_W-1:0] count_q;

	alt_pkg::cmd_t    item_q;
	alt_pkg::scan_t   scan_q;
	logic [IDX_W-1:0] mac_idx_q, addr_idx_q, free_idx_q;
	logic [alt_pkg::POOL_OFF_W-1:0] off_q;

	// Decision taken before the response goes out.
	alt_pkg::rsp_t    res_q, res_d;
	logic             lease_q, stamp_q, clear_q, inc_q, dec_q, tinc_q;
	logic             lease_d, stamp_d, clear_d, inc_d, dec_d, tinc_d;
	logic [IDX_W-1:0] widx_q, widx_d;
	logic             dec_load;

	logic inject, scan_load, off_clr, off_inc, emit;

	alt_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// Chain wiring.
	alt_pkg::query_t   query;
	alt_pkg::cell_wr_t wr;
	alt_pkg::scan_t    tok [0:LEASE_SLOTS];
	logic [IDX_W-1:0]  mi [0:LEASE_SLOTS];
	logic [IDX_W-1:0]  ai [0:LEASE_SLOTS];
	logic [IDX_W-1:0]  fi [0:LEASE_SLOTS];
	logic              last_tv;

	// Derived checks for the decision step.
	logic [31:0] req_off, age;
	logic        in_pool, held_live, cnt_full, is_disc;

	assign query.mac        = item_q.client_mac;
	assign query.req        = item_q.requested_ip;
	assign query.pool_start = pool_start_q;
	assign query.pool_size  = pool_size_q;

	always_comb begin
		tok[0]    = '0;
		tok[0].tv = inject;
		mi[0]     = '0;
		ai[0]     = '0;
		fi[0]     = '0;
	end

	genvar g;
	generate
		for (g = 0; g < LEASE_SLOTS; g++) begin : g_cell
			alt_cell #(
				.IDX_W   (IDX_W),
				.CELL_IDX(g)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.query       (query),
				.wr          (wr),
				.wr_idx      (widx_q),
				.tok_in      (tok[g]),
				.mac_idx_in  (mi[g]),
				.addr_idx_in (ai[g]),
				.free_idx_in (fi[g]),
				.tok_out     (tok[g+1]),
				.mac_idx_out (mi[g+1]),
				.addr_idx_out(ai[g+1]),
				.free_idx_out(fi[g+1])
			);
		end
	endgenerate

	assign last_tv = tok[LEASE_SLOTS].tv;

	// Writes go to the cells in the same cycle that the response is issued.
	always_comb begin
		wr            = '0;
		wr.en         = emit;
		wr.load_lease = lease_q;
		wr.load_stamp = stamp_q;
		wr.clear      = clear_q;
		wr.mac        = item_q.client_mac;
		wr.addr       = item_q.requested_ip;
		wr.stamp      = tick_q;
	end

	assign req_off   = item_q.requested_ip - pool_start_q;
	assign in_pool   = req_off < 32'(pool_size_q);
	assign age       = tick_q - scan_q.addr_stamp;
	assign held_live = scan_q.addr_hit && (age < duration_q) &&
	                   (scan_q.addr_mac != item_q.client_mac);
	assign cnt_full  = CMP_W'(count_q) >= CMP_W'(pool_size_q);
	assign is_disc   = (item_q.mode == alt_pkg::MODE_DISCOVER);

	// Next state and the decision for the current item.
	always_comb begin
		state_d   = state_q;
		dec_load  = 1'b0;
		res_d     = '{reply_kind: alt_pkg::KIND_NONE, assigned_ip: 32'd0,
		              status_code: alt_pkg::STAT_OK};
		lease_d   = 1'b0;
		stamp_d   = 1'b0;
		clear_d   = 1'b0;
		inc_d     = 1'b0;
		dec_d     = 1'b0;
		tinc_d    = 1'b0;
		widx_d    = mac_idx_q;
		inject    = 1'b0;
		scan_load = 1'b0;
		off_clr   = 1'b0;
		off_inc   = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			alt_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.mode)
						alt_pkg::MODE_TICK: begin
							dec_load = 1'b1;
							tinc_d   = 1'b1;
							state_d  = alt_pkg::ST_FIN;
						end
						alt_pkg::MODE_DISCOVER, alt_pkg::MODE_SELECT,
						alt_pkg::MODE_RENEW, alt_pkg::MODE_RELEASE: begin
							state_d = alt_pkg::ST_INJECT;
						end
						default: begin
							dec_load          = 1'b1;
							res_d.status_code = alt_pkg::STAT_REFUSED;
							state_d           = alt_pkg::ST_FIN;
						end
					endcase
				end
			end
			alt_pkg::ST_INJECT: begin
				inject  = 1'b1;
				state_d = alt_pkg::ST_SCAN;
			end
			alt_pkg::ST_SCAN: begin
				if (last_tv) begin
					scan_load = 1'b1;
					state_d   = alt_pkg::ST_EVAL;
				end
			end
			alt_pkg::ST_EVAL: begin
				state_d = alt_pkg::ST_FIN;
				unique case (item_q.mode)
					alt_pkg::MODE_SELECT: begin
						dec_load = 1'b1;
						if (!in_pool || held_live) begin
							res_d.reply_kind  = alt_pkg::KIND_NAK;
							res_d.status_code = alt_pkg::STAT_REFUSED;
						end else if (scan_q.addr_hit || scan_q.mac_hit ||
						             scan_q.free_hit) begin
							lease_d           = 1'b1;
							res_d.reply_kind  = alt_pkg::KIND_ACK;
							res_d.assigned_ip = item_q.requested_ip;
							if (scan_q.addr_hit) begin
								widx_d = addr_idx_q;
							end else if (scan_q.mac_hit) begin
								widx_d = mac_idx_q;
							end else begin
								widx_d = free_idx_q;
								inc_d  = 1'b1;
							end
						end else begin
							res_d.reply_kind  = alt_pkg::KIND_NAK;
							res_d.status_code = alt_pkg::STAT_FULL;
						end
					end
					alt_pkg::MODE_RELEASE: begin
						dec_load = 1'b1;
						if (scan_q.mac_hit) begin
							clear_d = 1'b1;
							dec_d   = 1'b1;
						end else begin
							res_d.status_code = alt_pkg::STAT_REFUSED;
						end
					end
					default: begin
						// Discover and renew share the address choice.
						if (scan_q.mac_hit) begin
							dec_load          = 1'b1;
							stamp_d           = 1'b1;
							res_d.reply_kind  = is_disc ? alt_pkg::KIND_OFFER
							                            : alt_pkg::KIND_ACK;
							res_d.assigned_ip = scan_q.mac_addr;
						end else if (cnt_full) begin
							dec_load          = 1'b1;
							res_d.reply_kind  = is_disc ? alt_pkg::KIND_NONE
							                            : alt_pkg::KIND_NAK;
							res_d.status_code = alt_pkg::STAT_EXHAUSTED;
						end else begin
							off_clr = 1'b1;
							state_d = alt_pkg::ST_WALK;
						end
					end
				endcase
			end
			alt_pkg::ST_WALK: begin
				if (off_q >= pool_size_q) begin
					dec_load          = 1'b1;
					res_d.reply_kind  = is_disc ? alt_pkg::KIND_NONE : alt_pkg::KIND_NAK;
					res_d.status_code = alt_pkg::STAT_EXHAUSTED;
					state_d           = alt_pkg::ST_FIN;
				end else if (!scan_q.taken[off_q]) begin
					dec_load          = 1'b1;
					res_d.reply_kind  = is_disc ? alt_pkg::KIND_OFFER : alt_pkg::KIND_ACK;
					res_d.assigned_ip = pool_start_q + 32'(off_q);
					state_d           = alt_pkg::ST_FIN;
				end else begin
					off_inc = 1'b1;
				end
			end
			alt_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					emit    = 1'b1;
					state_d = alt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = alt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: configuration, counters, decision flags, response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_start_q <= 32'd0;
			pool_size_q  <= 7'd64;
			duration_q   <= 32'd3600;
			tick_q       <= 32'd0;
			count_q      <= '0;
			lease_q      <= 1'b0;
			stamp_q      <= 1'b0;
			clear_q      <= 1'b0;
			inc_q        <= 1'b0;
			dec_q        <= 1'b0;
			tinc_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					alt_pkg::CFG_POOL_START:     pool_start_q <= cfg_data;
					alt_pkg::CFG_POOL_SIZE:      pool_size_q  <= cfg_data[6:0];
					alt_pkg::CFG_LEASE_DURATION: duration_q   <= cfg_data;
					default: ;
				endcase
			end
			if (dec_load) begin
				lease_q <= lease_d;
				stamp_q <= stamp_d;
				clear_q <= clear_d;
				inc_q   <= inc_d;
				dec_q   <= dec_d;
				tinc_q  <= tinc_d;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
				if (tinc_q) begin
					tick_q <= tick_q + 32'd1;
				end
				if (inc_q) begin
					count_q <= count_q + CNT_W'(1);
				end else if (dec_q) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == alt_pkg::ST_IDLE && cmd_valid) begin
			item_q <= cmd;
		end
		if (scan_load) begin
			scan_q     <= tok[LEASE_SLOTS];
			mac_idx_q  <= mi[LEASE_SLOTS];
			addr_idx_q <= ai[LEASE_SLOTS];
			free_idx_q <= fi[LEASE_SLOTS];
		end
		if (off_clr) begin
			off_q <= '0;
		end else if (off_inc) begin
			off_q <= off_q + alt_pkg::POOL_OFF_W'(1);
		end
		if (dec_load) begin
			res_q  <= res_d;
			widx_q <= widx_d;
		end
		if (emit) begin
			rsp_q <= res_q;
		end
	end

	assign cmd_stall = (state_q != alt_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// The token reaches the last cell's output after passing every cell register.
	a_token_latency: assert property (@(posedge clk) disable iff (!arst_n)
		inject |-> ##LEASE_SLOTS last_tv)
		else $error("scan token latency mismatch");

	// The lease count never exceeds the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("lease count overflow");

	// A response appears only as the finishing step hands it over.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == alt_pkg::ST_FIN)
		else $error("response without finishing step");

	// A release never frees a slot while the count is already zero.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && dec_q) |-> count_q != '0)
		else $error("lease count underflow");
`endif

endmodule

FILE: bench/address_lease_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address lease table core testbench
// Drives command items through the valid/stall channel with random idling and
// a long response hold-off. Each response is compared field by field with the
// bench's lease model or a typed row's value. Directed rows come first, then
// random sessions, over several pool and lease-duration settings.
// ----------------------------------------------------------------------------
module address_lease_table_core_tb;

	localparam int SLOTS     = 64;
	localparam int CYC_LIMIT = 1000000;
	localparam int HOLD_LEN  = 3000;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	alt_pkg::cmd_t cmd;
	logic          rsp_valid;
	logic          rsp_stall;
	alt_pkg::rsp_t rsp;
	logic          cfg_wen;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_data;

	address_lease_table_core #(.LEASE_SLOTS(SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Shadow lease table and configuration.
	logic [31:0] sh_pool_start;
	logic [6:0]  sh_pool_size;
	logic [31:0] sh_duration;
	logic        sh_valid [SLOTS];
	logic [47:0] sh_mac   [SLOTS];
	logic [31:0] sh_addr  [SLOTS];
	logic [31:0] sh_stamp [SLOTS];
	int          sh_count;
	logic [31:0] sh_ticks;

	alt_pkg::rsp_t reply_queue [$];
	int   fail_cnt, rsp_cnt, cmd_cnt, cycle_cnt;
	bit   idle_en;      // random idling on both sides
	bit   hold_start;   // asks the response side for one long hold-off
	logic hold_req;
	int   hold_cycles;
	int   n_ack, n_nak, n_offer, n_full, n_exh;

	// A fixed set of eight MACs that random sessions reuse, so they hit real leases.
	logic [47:0] mac_pool [8];

	function automatic int lease_by_mac(logic [47:0] m);
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && sh_mac[i] == m) return i;
		return -1;
	endfunction

	function automatic int lease_by_addr(logic [31:0] a);
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && sh_addr[i] == a) return i;
		return -1;
	endfunction

	// Finds the client's address, refreshing its stamp, or the lowest free pool address.
	function automatic bit pick_address(logic [47:0] m, output logic [31:0] a);
		int s;
		logic [31:0] cand;
		a = '0;
		s = lease_by_mac(m);
		if (s >= 0) begin
			sh_stamp[s] = sh_ticks;
			a = sh_addr[s];
			return 1'b1;
		end
		if (sh_count >= int'(sh_pool_size)) return 1'b0;
		for (int off = 0; off < int'(sh_pool_size); off++) begin
			cand = sh_pool_start + 32'(off);
			if (lease_by_addr(cand) < 0) begin
				a = cand;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic alt_pkg::rsp_t lease_step(alt_pkg::cmd_t c);
		alt_pkg::rsp_t r;
		logic [31:0] a, age;
		int s;
		r = '{alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_OK};
		case (c.mode)
			alt_pkg::MODE_TICK: sh_ticks = sh_ticks + 32'd1;
			alt_pkg::MODE_DISCOVER: begin
				if (pick_address(c.client_mac, a)) begin
					r.reply_kind = alt_pkg::KIND_OFFER; r.assigned_ip = a;
				end else r.status_code = alt_pkg::STAT_EXHAUSTED;
			end
			alt_pkg::MODE_RENEW: begin
				if (pick_address(c.client_mac, a)) begin
					r.reply_kind = alt_pkg::KIND_ACK; r.assigned_ip = a;
				end else begin
					r.reply_kind = alt_pkg::KIND_NAK;
					r.status_code = alt_pkg::STAT_EXHAUSTED;
				end
			end
			alt_pkg::MODE_SELECT: begin
				if (c.requested_ip - sh_pool_start >= {25'd0, sh_pool_size}) begin
					r.reply_kind = alt_pkg::KIND_NAK; r.status_code = alt_pkg::STAT_REFUSED;
				end else begin
					s = lease_by_addr(c.requested_ip);
					age = '0;
					if (s >= 0) age = sh_ticks - sh_stamp[s];
					if (s >= 0 && age < sh_duration && sh_mac[s] != c.client_mac) begin
						r.reply_kind = alt_pkg::KIND_NAK;
						r.status_code = alt_pkg::STAT_REFUSED;
					end else begin
						if (s < 0) s = lease_by_mac(c.client_mac);
						if (s < 0) begin
							for (int i = 0; i < SLOTS; i++)
								if (!sh_valid[i]) begin s = i; break; end
							if (s >= 0) begin
								sh_valid[s] = 1'b1;
								sh_count++;
							end
						end
						if (s < 0) begin
							r.reply_kind = alt_pkg::KIND_NAK;
							r.status_code = alt_pkg::STAT_FULL;
						end else begin
							sh_mac[s] = c.client_mac;
							sh_addr[s] = c.requested_ip;
							sh_stamp[s] = sh_ticks;
							r.reply_kind = alt_pkg::KIND_ACK;
							r.assigned_ip = c.requested_ip;
						end
					end
				end
			end
			alt_pkg::MODE_RELEASE: begin
				s = lease_by_mac(c.client_mac);
				if (s >= 0) begin
					sh_valid[s] = 1'b0;
					sh_count--;
				end else r.status_code = alt_pkg::STAT_REFUSED;
			end
			default: r.status_code = alt_pkg::STAT_REFUSED;
		endcase
		return r;
	endfunction

	// Writes one register, drops the enable after the write edge, then updates the shadow.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_wen <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			alt_pkg::CFG_POOL_START:     sh_pool_start = val;
			alt_pkg::CFG_POOL_SIZE:      sh_pool_size = val[6:0];
			alt_pkg::CFG_LEASE_DURATION: sh_duration = val;
			default: ;
		endcase
	endtask

	// Offers one item, with a random gap first when idling is on, and holds it until taken.
	// Valid stays high after acceptance; the next call replaces or drops it, or drain drops it.
	// A typed row replaces the model's expectation with the table value.
	task automatic send_cmd(alt_pkg::cmd_t c, bit typed, alt_pkg::rsp_t typed_rsp);
		alt_pkg::rsp_t e;
		while (idle_en && $urandom_range(99) < 32) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1; cmd <= c;
		do @(posedge clk); while (cmd_stall);
		e = lease_step(c);
		if (typed) e = typed_rsp;
		reply_queue.push_back(e);
		cmd_cnt++;
		case (e.reply_kind)
			alt_pkg::KIND_ACK:   n_ack++;
			alt_pkg::KIND_NAK:   n_nak++;
			alt_pkg::KIND_OFFER: n_offer++;
			default: ;
		endcase
		if (e.status_code == alt_pkg::STAT_FULL) n_full++;
		if (e.status_code == alt_pkg::STAT_EXHAUSTED) n_exh++;
	endtask

	// Waits for the block to drain before a register write.
	task automatic drain;
		cmd_valid <= 1'b0;
		while (reply_queue.size() != 0) @(posedge clk);
		repeat (SLOTS + 140) @(posedge clk);
	endtask

	// Long response hold-off, counted here once it has been asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_req    <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_start && hold_cycles < HOLD_LEN) begin
			hold_req    <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			hold_req <= 1'b0;
		end
	end

	// Response side: random stalls, plus the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= hold_req || (idle_en && ($urandom_range(99) < 32));
		end
	end

	// Checker: an item is taken when valid and not stalled at the edge.
	alt_pkg::rsp_t exp_rsp;
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_cnt++;
			if (reply_queue.size() == 0) begin
				$display("%0t: unexpected response %h", $time, rsp);
				fail_cnt++;
			end else begin
				exp_rsp = reply_queue.pop_front();
				if (rsp.reply_kind !== exp_rsp.reply_kind) begin
					$display("%0t: reply_kind expected %0d actual %0d",
						$time, exp_rsp.reply_kind, rsp.reply_kind);
					fail_cnt++;
				end
				if (rsp.assigned_ip !== exp_rsp.assigned_ip) begin
					$display("%0t: assigned_ip expected %h actual %h",
						$time, exp_rsp.assigned_ip, rsp.assigned_ip);
					fail_cnt++;
				end
				if (rsp.status_code !== exp_rsp.status_code) begin
					$display("%0t: status_code expected %0d actual %0d",
						$time, exp_rsp.status_code, rsp.status_code);
					fail_cnt++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYC_LIMIT) begin
			$display("address_lease_table_core test failed");
			$finish;
		end
	end

	// Directed rows. Expectations are typed in only where obvious; the rest
	// rely on the model.
	typedef struct {
		logic [2:0]    mode;
		logic [47:0]   mac;
		logic [31:0]   req;
		bit            typed;
		alt_pkg::rsp_t r;
	} row_t;

	row_t rows [$];

	function automatic row_t mk(logic [2:0] m, logic [47:0] mac, logic [31:0] q,
			bit t, logic [1:0] k, logic [31:0] ip, logic [1:0] st);
		row_t w;
		w.mode = m; w.mac = mac; w.req = q; w.typed = t;
		w.r = '{k, ip, st};
		return w;
	endfunction

	task automatic random_item(int pool_span);
		alt_pkg::cmd_t c;
		int   pick;
		c.client_mac = mac_pool[$urandom_range(7)];
		if ($urandom_range(9) == 0) c.client_mac = 48'({$urandom, $urandom});
		c.requested_ip = sh_pool_start + 32'($urandom_range(pool_span + 1));
		if ($urandom_range(9) == 0) c.requested_ip = $urandom;
		pick = $urandom_range(99);
		if (pick < 15)      c.mode = alt_pkg::MODE_TICK;
		else if (pick < 35) c.mode = alt_pkg::MODE_DISCOVER;
		else if (pick < 65) c.mode = alt_pkg::MODE_SELECT;
		else if (pick < 80) c.mode = alt_pkg::MODE_RENEW;
		else if (pick < 96) c.mode = alt_pkg::MODE_RELEASE;
		else                c.mode = 3'($urandom_range(7, 5));
		send_cmd(c, 1'b0, '0);
	endtask

	alt_pkg::cmd_t c0;
	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0; cmd = '0;
		cfg_wen = 1'b0; cfg_index = alt_pkg::CFG_POOL_START; cfg_data = '0;
		hold_start = 1'b0; idle_en = 1'b0;
		fail_cnt = 0; rsp_cnt = 0; cmd_cnt = 0; cycle_cnt = 0;
		n_ack = 0; n_nak = 0; n_offer = 0; n_full = 0; n_exh = 0;
		sh_pool_start = 32'd0; sh_pool_size = 7'd64; sh_duration = 32'd3600;
		sh_count = 0; sh_ticks = '0;
		for (int i = 0; i < SLOTS; i++) begin
			sh_valid[i] = 1'b0; sh_mac[i] = '0; sh_addr[i] = '0; sh_stamp[i] = '0;
		end
		mac_pool[0] = 48'h0; mac_pool[1] = 48'hFFFF_FFFF_FFFF;
		for (int i = 2; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset configuration: pool 0..63.
		rows.push_back(mk(alt_pkg::MODE_DISCOVER, 48'h0, 32'd0, 1'b1,
			alt_pkg::KIND_OFFER, 32'd0, alt_pkg::STAT_OK));
		rows.push_back(mk(alt_pkg::MODE_RELEASE, 48'h0, 32'd0, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(alt_pkg::MODE_TICK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_OK));
		rows.push_back(mk(alt_pkg::MODE_SELECT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			alt_pkg::KIND_NAK, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(alt_pkg::MODE_SELECT, 48'hFFFF_FFFF_FFFF, 32'd63, 1'b1,
			alt_pkg::KIND_ACK, 32'd63, alt_pkg::STAT_OK));
		rows.push_back(mk(alt_pkg::MODE_SELECT, 48'h0, 32'd63, 1'b1,
			alt_pkg::KIND_NAK, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(alt_pkg::MODE_SELECT, 48'h0, 32'd0, 1'b1,
			alt_pkg::KIND_ACK, 32'd0, alt_pkg::STAT_OK));
		rows.push_back(mk(alt_pkg::MODE_DISCOVER, 48'h5, 32'd0, 1'b0, 2'd0, 32'd0, 2'd0));
		rows.push_back(mk(alt_pkg::MODE_RENEW, 48'h0, 32'd0, 1'b0, 2'd0, 32'd0, 2'd0));
		rows.push_back(mk(alt_pkg::MODE_SELECT, 48'h0, 32'd5, 1'b0, 2'd0, 32'd0, 2'd0));
		rows.push_back(mk(alt_pkg::MODE_RENEW, 48'h123456, 32'd0, 1'b0, 2'd0, 32'd0, 2'd0));
		rows.push_back(mk(3'd5, 48'h1, 32'd1, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(3'd6, 48'h1, 32'd1, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(3'd7, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_REFUSED));
		rows.push_back(mk(alt_pkg::MODE_RELEASE, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_OK));
		rows.push_back(mk(alt_pkg::MODE_RELEASE, 48'h0, 32'd0, 1'b1,
			alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_OK));
		foreach (rows[i]) begin
			c0.mode = rows[i].mode; c0.client_mac = rows[i].mac;
			c0.requested_ip = rows[i].req;
			send_cmd(c0, rows[i].typed, rows[i].r);
		end
		drain();

		// Tiny pool with one-tick leases: exhaustion, takeover of an
		// expired lease, and a request just past the top of the address space.
		write_reg(alt_pkg::CFG_POOL_START, 32'hFFFF_FFFF);
		write_reg(alt_pkg::CFG_POOL_SIZE, 32'd1);
		write_reg(alt_pkg::CFG_LEASE_DURATION, 32'd1);
		c0 = '{alt_pkg::MODE_SELECT, 48'h11, 32'hFFFF_FFFF};   send_cmd(c0, 1'b0, '0);
		c0 = '{alt_pkg::MODE_DISCOVER, 48'h22, 32'd0};         send_cmd(c0, 1'b0, '0);
		c0 = '{alt_pkg::MODE_RENEW, 48'h22, 32'd0};            send_cmd(c0, 1'b0, '0);
		c0 = '{alt_pkg::MODE_TICK, 48'h0, 32'd0};              send_cmd(c0, 1'b0, '0);
		c0 = '{alt_pkg::MODE_SELECT, 48'h22, 32'hFFFF_FFFF};   send_cmd(c0, 1'b0, '0);
		c0 = '{alt_pkg::MODE_SELECT, 48'h22, 32'h0};           send_cmd(c0, 1'b0, '0);
		drain();

		// Full table: 64 leases then one more client. Long response hold-off
		// while the sender keeps offering items.
		write_reg(alt_pkg::CFG_POOL_START, 32'h0A00_0000);
		write_reg(alt_pkg::CFG_POOL_SIZE, 32'd64);
		write_reg(alt_pkg::CFG_LEASE_DURATION, 32'hFFFF_FFFF);
		idle_en = 1'b1;
		hold_start = 1'b1;
		for (int i = 0; i < 65; i++) begin
			c0 = '{alt_pkg::MODE_SELECT, 48'h1000 + 48'(i), 32'h0A00_0000 + 32'(i % 64)};
			if (i == 64) c0.requested_ip = 32'h0A00_0010;
			send_cmd(c0, 1'b0, '0);
		end
		drain();
		// Move the pool so that a new client's address is held by no slot.
		write_reg(alt_pkg::CFG_POOL_START, 32'h0B00_0000);
		c0 = '{alt_pkg::MODE_SELECT, 48'h9999, 32'h0B00_0000};
		send_cmd(c0, 1'b1, '{alt_pkg::KIND_NAK, 32'd0, alt_pkg::STAT_FULL});
		c0 = '{alt_pkg::MODE_DISCOVER, 48'h9999, 32'd0};
		send_cmd(c0, 1'b1, '{alt_pkg::KIND_NONE, 32'd0, alt_pkg::STAT_EXHAUSTED});
		drain();
		for (int i = 0; i < 8; i++) begin
			c0 = '{alt_pkg::MODE_RELEASE, 48'h1000 + 48'(i * 8), 32'd0};
			send_cmd(c0, 1'b0, '0);
		end
		drain();

		// Random sessions over a few settings; one stretch without idling.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(alt_pkg::CFG_POOL_START, $urandom);
					write_reg(alt_pkg::CFG_POOL_SIZE, 32'd4);
					write_reg(alt_pkg::CFG_LEASE_DURATION, 32'd3); end
				1: begin write_reg(alt_pkg::CFG_POOL_START, 32'h0);
					write_reg(alt_pkg::CFG_POOL_SIZE, 32'd8);
					write_reg(alt_pkg::CFG_LEASE_DURATION, 32'd10); end
				2: begin write_reg(alt_pkg::CFG_POOL_START, 32'hFFFF_FFFC);
					write_reg(alt_pkg::CFG_POOL_SIZE, 32'd6);
					write_reg(alt_pkg::CFG_LEASE_DURATION, 32'd2); end
				default: begin write_reg(alt_pkg::CFG_POOL_START, $urandom);
					write_reg(alt_pkg::CFG_POOL_SIZE, 32'd64);
					write_reg(alt_pkg::CFG_LEASE_DURATION, 32'd3600); end
			endcase
			idle_en = (ph != 1);
			for (int i = 0; i < 12; i++) random_item(int'(sh_pool_size));
			drain();
		end

		$display("Covered %0d items, %0d responses: %0d offers, %0d acks, %0d naks,",
			cmd_cnt, rsp_cnt, n_offer, n_ack, n_nak);
		$display("%0d table-full and %0d pool-exhausted replies over several settings.",
			n_full, n_exh);
		if (fail_cnt == 0 && reply_queue.size() == 0)
			$display("address_lease_table_core test passed");
		else
			$display("address_lease_table_core test failed");
		$finish;
	end

endmodule
